/* src/dalarm_pkg.sv */
// Shared constants and types for the daily alarm slot block.
package dalarm_pkg;

  localparam int unsigned MaxSlots   = 5;
  localparam int unsigned SlotCount  = 5;
  localparam int unsigned TimeW      = 11;
  localparam int unsigned HourW      = 5;
  localparam int unsigned MinuteW    = 6;
  localparam int unsigned SeenW      = 7;
  localparam int unsigned ActiveW    = 3;
  localparam int unsigned RingW      = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;

  localparam logic [TimeW-1:0]   MinPerHour  = TimeW'(60);
  localparam logic [SeenW-1:0]   SeenNone    = '1;
  localparam logic [ActiveW-1:0] ActiveReset = ActiveW'(5);
  localparam logic [RingW-1:0]   RingReset   = RingW'(5000);
  localparam logic [RingW-1:0]   RingMax     = '1;

  // Default alarm times: 08:00, 10:00, 12:00, 14:00, 16:00
  localparam logic [TimeW-1:0] SlotReset [MaxSlots] = '{
    TimeW'(480), TimeW'(600), TimeW'(720), TimeW'(840), TimeW'(960)
  };

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SLOT0  = 3'd0,
    REG_SLOT1  = 3'd1,
    REG_SLOT2  = 3'd2,
    REG_SLOT3  = 3'd3,
    REG_SLOT4  = 3'd4,
    REG_ACTIVE = 3'd5,
    REG_RING   = 3'd6
  } reg_idx_e;

  // Scalar settings handed from the register file to the datapath
  typedef struct packed {
    logic [ActiveW-1:0] active_slots;
    logic [RingW-1:0]   ring_ticks;
  } cfg_t;

endpackage

/* src/dalarm_cfg.sv */
// Configuration register file: slot times, active slot count and ring length.
module dalarm_cfg import dalarm_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [TimeW-1:0]    slot_time_o [SLOT_COUNT],
  output cfg_t                cfg_o
);

  logic [TimeW-1:0] slot_q [SLOT_COUNT];
  cfg_t             cfg_q;

  // Take slot time writes; indexes past the built slots are dropped
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_q[i] <= SlotReset[i];
      end else if (cfg_valid_i && (cfg_index_i == CfgIdxW'(i))) begin
        slot_q[i] <= cfg_data_i[TimeW-1:0];
      end
    end
    assign slot_time_o[i] = slot_q[i];
  end

  // Decode the scalar settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_slots <= ActiveReset;
      cfg_q.ring_ticks   <= RingReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ACTIVE: cfg_q.active_slots <= cfg_data_i[ActiveW-1:0];
        REG_RING:   cfg_q.ring_ticks   <= cfg_data_i[RingW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/dalarm_next.sv */
// Earliest active slot time strictly later than the current time of day.
module dalarm_next import dalarm_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCount
) (
  input  logic [TimeW-1:0]      slot_time_i [SLOT_COUNT],
  input  logic [SLOT_COUNT-1:0] active_i,
  input  logic [TimeW-1:0]      now_i,
  output logic                  next_valid_o,
  output logic [TimeW-1:0]      next_time_o
);

  logic [SLOT_COUNT-1:0] later;

  // Flag each active slot that lies after now
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      later[i] = active_i[i] && (slot_time_i[i] > now_i);
    end
  end

  // Scan the few candidates for the smallest time
  always_comb begin
    next_valid_o = 1'b0;
    next_time_o  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (later[i] && (!next_valid_o || (slot_time_i[i] < next_time_o))) begin
        next_valid_o = 1'b1;
        next_time_o  = slot_time_i[i];
      end
    end
  end

endmodule

/* src/dalarm_core.sv */
// Alarm state: fired marks, minute tracking and the bell with its tick timer.
module dalarm_core import dalarm_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCount
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [HourW-1:0]   hour_i,
  input  logic [MinuteW-1:0] minute_i,
  input  logic               press_i,
  input  logic [TimeW-1:0]   slot_time_i [SLOT_COUNT],
  input  cfg_t               cfg_i,
  output logic               bell_on_o,
  output logic               next_valid_o,
  output logic [TimeW-1:0]   next_time_o
);

  logic [SeenW-1:0]      seen_q, seen_d;
  logic [SLOT_COUNT-1:0] fired_q, fired_d;
  logic                  ringing_q, ringing_d;
  logic [RingW-1:0]      elapsed_q, elapsed_d;

  logic [TimeW-1:0]      now;
  logic [SLOT_COUNT-1:0] active;
  logic [SLOT_COUNT-1:0] hit;
  logic                  minute_ok;
  logic [SLOT_COUNT-1:0] marks;
  logic [RingW-1:0]      tick;

  // Minutes of day; an out-of-range minute never matches a slot time
  assign now       = TimeW'(hour_i) * MinPerHour + TimeW'(minute_i);
  assign minute_ok = (TimeW'(minute_i) < MinPerHour);

  // Slots beyond the active count (or the built count) take no part
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      active[i] = (cfg_i.active_slots > ActiveW'(i));
    end
  end

  // Clear marks on a new minute, then match unfired slots
  always_comb begin
    marks = ({1'b0, minute_i} != seen_q) ? '0 : fired_q;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i] = active[i] && minute_ok && (slot_time_i[i] == now) && !marks[i];
    end
  end

  // Advance the tick timer, start on a match, toggle on a press, stop on timeout
  always_comb begin
    tick      = (ringing_q && (elapsed_q != RingMax)) ? elapsed_q + RingW'(1) : elapsed_q;
    seen_d    = {1'b0, minute_i};
    fired_d   = marks | hit;
    ringing_d = ringing_q;
    elapsed_d = tick;
    if (|hit) begin
      ringing_d = 1'b1;
      elapsed_d = '0;
    end
    if (press_i) begin
      if (ringing_d) begin
        ringing_d = 1'b0;
      end else begin
        ringing_d = 1'b1;
        elapsed_d = '0;
      end
    end
    if (ringing_d && (elapsed_d > cfg_i.ring_ticks)) begin
      ringing_d = 1'b0;
    end
  end

  // Hold state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= SeenNone;
      fired_q   <= '0;
      ringing_q <= 1'b0;
      elapsed_q <= '0;
    end else if (step_i) begin
      seen_q    <= seen_d;
      fired_q   <= fired_d;
      ringing_q <= ringing_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign bell_on_o = ringing_d;

  dalarm_next #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_next (
    .slot_time_i (slot_time_i),
    .active_i    (active),
    .now_i       (now),
    .next_valid_o(next_valid_o),
    .next_time_o (next_time_o)
  );

endmodule

/* src/daily_alarm_slots_with_ring_timer.sv */
// A tick request is captured in the input register and its result in the result register.
// One tick per cycle while results are taken; the slot match and next-time scan are
// combinational between the input register and the result register.
// While a finished result waits, the input register takes one more tick, then stalls requests.
// Reset (rst_ni low, asynchronous) empties both registers, clears fired marks
// and the bell, and loads the default slot times, slot count and ring length.
module daily_alarm_slots_with_ring_timer import dalarm_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Tick requests
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,  // hour_now[4:0], minute_now[10:5], button_press[11]
  // Results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,  // bell_on[0], next_time[11:1]
  output logic                 m_axis_tuser,  // next_valid[0]
  // Register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic               in_valid_q;
  logic [HourW-1:0]   hour_q;
  logic [MinuteW-1:0] minute_q;
  logic               press_q;
  logic               out_valid_q;
  logic               bell_q;
  logic               next_valid_q;
  logic [TimeW-1:0]   next_time_q;

  logic               step;
  logic               bell_on;
  logic               next_valid;
  logic [TimeW-1:0]   next_time;
  logic [TimeW-1:0]   slot_time [SLOT_COUNT];
  cfg_t               cfg;

  assign cfg_ready_o   = 1'b1;
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      hour_q   <= s_axis_tdata[HourW-1:0];
      minute_q <= s_axis_tdata[HourW+MinuteW-1:HourW];
      press_q  <= s_axis_tdata[HourW+MinuteW];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      bell_q       <= bell_on;
      next_valid_q <= next_valid;
      next_time_q  <= next_time;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW-TimeW-1)'(0), next_time_q, bell_q};
  assign m_axis_tuser  = next_valid_q;

  dalarm_cfg #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .slot_time_o(slot_time),
    .cfg_o      (cfg)
  );

  dalarm_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .hour_i      (hour_q),
    .minute_i    (minute_q),
    .press_i     (press_q),
    .slot_time_i (slot_time),
    .cfg_i       (cfg),
    .bell_on_o   (bell_on),
    .next_valid_o(next_valid),
    .next_time_o (next_time)
  );

endmodule

/* src/dalarm_chk.sv */
// Port-level checks for the alarm block, bound to the top level.
module dalarm_chk import dalarm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A fresh result follows an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching request");

  // Requests are refused only while a result is stuck downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request refused with a free result register");

  // No later slot means a zero next time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[TimeW:1] == '0)
    else $error("next time set without a later slot");

endmodule

bind daily_alarm_slots_with_ring_timer dalarm_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
